// ----- design/srma_pkg.sv -----
// shared types and constants of the spi register access master
// depends on nothing; every other design file imports it
`timescale 1ns / 1ps
`default_nettype none

package srma_pkg;

	localparam int unsigned FrameBits = 24;
	localparam int unsigned AddrW     = 15;
	localparam int unsigned DataW     = 8;
	localparam int unsigned PosW      = 5;

	localparam logic [PosW-1:0]  LastBit   = PosW'(FrameBits - 1);
	localparam logic [DataW-1:0] ReadFill  = 8'h00;

	typedef enum logic [0:0] {
		REQ_START = 1'b0,
		REQ_TICK  = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t         req_type;
		logic              is_read;
		logic [AddrW-1:0]  reg_addr;
		logic [DataW-1:0]  write_data;
		logic              miso_bit;
	} srma_req_t;

	typedef struct packed {
		logic              chip_select_active;
		logic              mosi_bit;
		logic [PosW-1:0]   bit_position;
		logic [DataW-1:0]  read_byte;
		logic              frame_done;
		logic              start_rejected;
	} srma_rsp_t;

endpackage

`default_nettype wire

// ----- design/srma_if.sv -----
// valid/ready channel interfaces for request and response beats
// depends on srma_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srma_req_if
	import srma_pkg::*;
;
	logic      valid;
	logic      ready;
	srma_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface srma_rsp_if
	import srma_pkg::*;
;
	logic      valid;
	logic      ready;
	srma_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/srma_core.sv -----
// frame state and per-beat response logic of the spi register access master
// depends on srma_pkg
`timescale 1ns / 1ps
`default_nettype none

module srma_core
	import srma_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire srma_req_t req,
	output srma_rsp_t      rsp
);

	logic                 busy_q;
	logic [PosW-1:0]      cnt_q;
	logic [FrameBits-1:0] tx_q;
	logic [DataW-1:0]     rx_q;

	logic                 last_bit;
	logic [DataW-1:0]     rx_next;
	logic [FrameBits-1:0] frame_load;

	assign last_bit   = (cnt_q >= LastBit);
	assign rx_next    = {rx_q[DataW-2:0], req.miso_bit};
	assign frame_load = {req.is_read, req.reg_addr,
		(req.is_read ? ReadFill : req.write_data)};

	always_comb begin
		rsp = '0;
		case (req.req_type)
			REQ_START: begin
				rsp.chip_select_active = 1'b1;
				rsp.start_rejected     = busy_q;
			end
			REQ_TICK: begin
				if (busy_q) begin
					rsp.mosi_bit           = tx_q[FrameBits-1];
					rsp.bit_position       = last_bit ? LastBit : cnt_q;
					rsp.read_byte          = last_bit ? rx_next : '0;
					rsp.frame_done         = last_bit;
					rsp.chip_select_active = !last_bit;
				end
			end
			default: rsp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			tx_q   <= '0;
			rx_q   <= '0;
		end else if (fire) begin
			if (req.req_type == REQ_START) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					rx_q   <= '0;
					tx_q   <= frame_load;
				end
			end else if (busy_q) begin
				tx_q <= {tx_q[FrameBits-2:0], 1'b0};
				rx_q <= rx_next;
				if (last_bit) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.frame_done |=> !busy_q)
		else $error("busy still set after final bit");
	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.req_type == REQ_START && !busy_q |=> busy_q && cnt_q == '0)
		else $error("accepted start did not open a frame");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LastBit)
		else $error("bit counter beyond last frame bit");
`endif

endmodule

`default_nettype wire

// ----- design/spi_register_access_master_top.sv -----
// top level of the spi register access master: input stage, core, response register
// depends on srma_pkg, srma_if and srma_core
//
//  channel | dir | beat payload | meaning
//  --------+-----+--------------+-------------------------------------------
//  req     | in  | srma_req_t   | start of a register access or one bit tick
//  rsp     | out | srma_rsp_t   | one response beat for every request beat
//
// every request beat yields one response beat through both registered stages;
// one beat per cycle is sustained while the response side is ready
// reset (arst_n low) clears the frame state and both stage valid flags at once
// a stalled response holds in its register; the input stage still takes a beat
// while the response register is free or being drained
`timescale 1ns / 1ps
`default_nettype none

module spi_register_access_master_top
	import srma_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	srma_req_if.sink  req,
	srma_rsp_if.source rsp
);

	// input stage
	logic      valid_s1;
	srma_req_t req_s1;

	// response stage
	logic      valid_s2;
	srma_rsp_t rsp_s2;

	logic      advance;
	srma_rsp_t core_rsp;

	// the response register moves when empty or drained this cycle
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// state advances only when the beat really leaves the input stage
	srma_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.req    (req_s1),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

`ifndef NO_ASSERTIONS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("input stage lost a beat under stall");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |=> valid_s2 && $stable(rsp_s2))
		else $error("response register changed under stall");
	a_done_no_cs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.frame_done |-> !rsp_s2.chip_select_active)
		else $error("chip select active on final bit");
`endif

endmodule

`default_nettype wire

// ----- bench/spi_register_access_master_top_tb.sv -----
// self-checking bench for spi_register_access_master_top: valid/ready beats in, frame results out
// depends on srma_pkg, srma_if and the design top; holds its own frame predictor and scoreboard
`timescale 1ns / 1ps

module spi_register_access_master_top_tb;
	import srma_pkg::*;

	// run shape
	localparam int unsigned ItemTarget  = 1750;  // request beats before the stimulus stops
	localparam int unsigned QuietTail   = 250;   // last beats run with no idling on either side
	localparam int unsigned LongHoldAt  = 400;   // request count that triggers the long response stall
	localparam int unsigned LongHoldLen = 60;    // cycles the response side holds off then
	localparam int unsigned SettleLen   = 8;     // wait after draining, leave some margin for a stray beat
	localparam int unsigned StallLimit  = 1000;  // cycles with no beat on either channel
	localparam int unsigned ReportMax   = 10;

	// frame predictor and in-order store of expected response beats
	class frame_scoreboard;
		logic                 busy;
		logic [PosW-1:0]      bit_idx;
		logic [FrameBits-1:0] tx_frame;
		logic [DataW-1:0]     rx_byte;
		srma_rsp_t            expected_rsps[$];
		int unsigned          error_count;

		function new();
			busy        = 1'b0;
			bit_idx     = '0;
			tx_frame    = '0;
			rx_byte     = '0;
			error_count = 0;
		endfunction

		// advance the frame state by one accepted request and queue its response
		function void note_request(srma_req_t r);
			srma_rsp_t e;
			e = '0;
			if (r.req_type == REQ_START) begin
				e.chip_select_active = 1'b1;
				if (busy) begin
					e.start_rejected = 1'b1;
				end else begin
					busy     = 1'b1;
					bit_idx  = '0;
					rx_byte  = '0;
					// r/w flag, address, then data byte (zero fill on a read)
					tx_frame = {r.is_read, r.reg_addr, r.is_read ? ReadFill : r.write_data};
				end
			end else if (busy) begin
				e.mosi_bit     = tx_frame[FrameBits-1];
				e.bit_position = bit_idx;
				tx_frame       = tx_frame << 1;
				rx_byte        = {rx_byte[DataW-2:0], r.miso_bit};
				if (bit_idx >= LastBit) begin
					e.bit_position = LastBit;
					e.read_byte    = rx_byte;
					e.frame_done   = 1'b1;
					busy           = 1'b0;
					bit_idx        = '0;
				end else begin
					bit_idx              = bit_idx + 1'b1;
					e.chip_select_active = 1'b1;
				end
			end
			expected_rsps.push_back(e);
		endfunction

		function void check_response(srma_rsp_t got);
			srma_rsp_t exp;
			string     diffs;
			if (expected_rsps.size() == 0) begin
				error_count++;
				if (error_count <= ReportMax)
					$display("%0t: response beat with nothing expected: %p", $realtime, got);
				return;
			end
			exp   = expected_rsps.pop_front();
			diffs = "";
			if (got.chip_select_active !== exp.chip_select_active)
				diffs = {diffs, $sformatf(" cs exp %b got %b",
					exp.chip_select_active, got.chip_select_active)};
			if (got.mosi_bit !== exp.mosi_bit)
				diffs = {diffs, $sformatf(" mosi exp %b got %b", exp.mosi_bit, got.mosi_bit)};
			if (got.bit_position !== exp.bit_position)
				diffs = {diffs, $sformatf(" pos exp %0d got %0d",
					exp.bit_position, got.bit_position)};
			if (got.read_byte !== exp.read_byte)
				diffs = {diffs, $sformatf(" rbyte exp %h got %h", exp.read_byte, got.read_byte)};
			if (got.frame_done !== exp.frame_done)
				diffs = {diffs, $sformatf(" done exp %b got %b", exp.frame_done, got.frame_done)};
			if (got.start_rejected !== exp.start_rejected)
				diffs = {diffs, $sformatf(" rej exp %b got %b",
					exp.start_rejected, got.start_rejected)};
			if (diffs != "") begin
				error_count++;
				if (error_count <= ReportMax)
					$display("%0t: response mismatch:%s", $realtime, diffs);
			end
		endfunction

		function int unsigned pending();
			return expected_rsps.size();
		endfunction

		function bit failed();
			return (error_count != 0) || (expected_rsps.size() != 0);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	srma_req_if req_bus ();
	srma_rsp_if rsp_bus ();

	spi_register_access_master_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	frame_scoreboard sb = new();

	int unsigned items_sent;   // request beats accepted, as seen by the sender
	int unsigned reqs_taken;   // request beats accepted, as seen by the monitor
	int unsigned idle_cycles;  // cycles since the last beat on either channel
	bit          quiet;        // set for the tail of the run: no idling anywhere

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	// random word biased toward all-zero and all-one, truncated by the caller
	function automatic logic [31:0] biased_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// start beat; the miso bit is ignored by the block so it is random
	function automatic srma_req_t start_item(logic rd, logic [AddrW-1:0] addr,
			logic [DataW-1:0] wdata);
		srma_req_t r;
		r.req_type   = REQ_START;
		r.is_read    = rd;
		r.reg_addr   = addr;
		r.write_data = wdata;
		r.miso_bit   = 1'($urandom);
		return r;
	endfunction

	// tick beat; the start-only fields ride along with random content
	function automatic srma_req_t tick_item(logic miso);
		srma_req_t r;
		r.req_type   = REQ_TICK;
		r.is_read    = 1'($urandom);
		r.reg_addr   = AddrW'($urandom);
		r.write_data = DataW'($urandom);
		r.miso_bit   = miso;
		return r;
	endfunction

	// offer one request beat, with a random idle burst in front of it outside the tail,
	// and return at the edge where it is taken
	task automatic send_req(srma_req_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data  <= r;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		items_sent++;
		if (items_sent >= ItemTarget - QuietTail)
			quiet = 1'b1;
	endtask

	// one whole frame: the start, then 24 ticks with random miso; a stray start
	// (which the block must reject) goes in before tick number stray_at, if in range
	task automatic run_frame(srma_req_t first, int stray_at);
		send_req(first);
		for (int k = 0; k < FrameBits; k++) begin
			if (k == stray_at)
				send_req(start_item(1'($urandom), AddrW'(biased_word()), DataW'(biased_word())));
			send_req(tick_item(1'($urandom)));
		end
	endtask

	// --------------------------------------------------------------------
	// monitor: note accepted requests, check accepted responses, track activity
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				sb.note_request(req_bus.data);
				reqs_taken++;
			end
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_response(rsp_bus.data);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// --------------------------------------------------------------------
	// response side: random stall bursts, one long hold-off so the block backs up
	// into its input, and always ready once the tail of the run starts
	// --------------------------------------------------------------------
	initial begin : rsp_side
		bit long_hold_done;
		long_hold_done = 1'b0;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && !long_hold_done && reqs_taken >= LongHoldAt) begin
				// sender keeps offering beats through this whole stretch
				long_hold_done = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (LongHoldLen - 1) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				// ready is dropped for a random burst of edges
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// --------------------------------------------------------------------
	// watchdog: ends the run if neither channel moves for too long
	// --------------------------------------------------------------------
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < StallLimit) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// --------------------------------------------------------------------
	// main sequence
	// --------------------------------------------------------------------
	initial begin : main_seq
		srma_req_t all_ones;
		int        stray_at;

		items_sent  = 0;
		reqs_taken  = 0;
		idle_cycles = 0;
		quiet       = 1'b0;

		arst_n        <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tick while idle with every ignored field set, then a write frame at
		// the largest address and data with a rejected start right after the frame opens
		all_ones = '1;
		send_req(all_ones);
		run_frame(start_item(1'b0, '1, '1), 0);

		// random frames; a few idle ticks and stray starts mixed in as noise
		while (items_sent < ItemTarget) begin
			if ($urandom_range(0, 9) == 0)
				send_req(tick_item(1'($urandom)));
			stray_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, FrameBits - 1)) : -1;
			run_frame(start_item(1'($urandom), AddrW'(biased_word()), DataW'(biased_word())),
				stray_at);
		end
		req_bus.valid <= 1'b0;

		// drain, then give the pipeline time to show any stray beat
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleLen) @(posedge clk);

		if (sb.failed())
			$display("Regression FAIL");
		else
			$display("Regression PASS");
		$finish;
	end

endmodule

// ----- spi_register_access_master_top.f -----
design/srma_pkg.sv
design/srma_if.sv
design/srma_core.sv
design/spi_register_access_master_top.sv
bench/spi_register_access_master_top_tb.sv
